[hw/rtl/utf8_stream_decoder_assert.svh]
// ---------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Property wrappers for the decoder checker.
// ---------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Checked only outside reset.
`define U8SD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define U8SD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/u8sd_pkg.sv]
// ---------------------------------------------------------------------------
// UTF-8 stream decoder package
// Widths, status codes, lead byte ranges and shared structs.
// ---------------------------------------------------------------------------
package u8sd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 31;
    localparam int LEFT_W  = 3;
    localparam int TDATA_W = 32;
    localparam int TUSER_W = 2;

    typedef enum logic [1:0] {
        ST_CHAR    = 2'd0,
        ST_END     = 2'd1,
        ST_ILLEGAL = 2'd2,
        ST_CUT     = 2'd3
    } status_t;

    // Lead byte ranges (inclusive upper bounds; LEAD2_MIN is the shared lower bound)
    localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF7;
    localparam logic [BYTE_W-1:0] LEAD5_MAX = 8'hFB;
    localparam logic [BYTE_W-1:0] LEAD6_MAX = 8'hFD;

    typedef struct packed {
        logic [LEFT_W-1:0] bytes_left;
        logic [CP_W-1:0]   accumulator;
        logic              halted;
    } dec_state_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
    } result_t;

endpackage

[hw/rtl/u8sd_step.sv]
// ---------------------------------------------------------------------------
// UTF-8 decoder step
// Next decoder state and optional result for one input byte.
// ---------------------------------------------------------------------------
module u8sd_step
    import u8sd_pkg::*;
(
    input  logic [BYTE_W-1:0] in_byte,
    input  dec_state_t        cur,
    output dec_state_t        nxt,
    output logic              emit,
    output result_t           res
);

    logic [CP_W-1:0]   acc_shift;
    logic [LEFT_W-1:0] left_dec;
    logic              is_nul;

    assign acc_shift = {cur.accumulator[CP_W-7:0], in_byte[5:0]};
    assign left_dec  = cur.bytes_left - LEFT_W'(1);
    assign is_nul    = (in_byte == '0);

    always_comb
    begin
        nxt            = cur;
        emit           = 1'b0;
        res.code_point = '0;
        res.status     = ST_CHAR;

        priority if (cur.halted)
        begin
            if (is_nul)
                nxt.halted = 1'b0;
        end
        else if (cur.bytes_left != '0)
        begin
            if (is_nul)
            begin
                nxt.bytes_left  = '0;
                nxt.accumulator = '0;
                emit            = 1'b1;
                res.status      = ST_CUT;
            end
            else
            begin
                // continuation bytes are not checked for 10xxxxxx
                nxt.bytes_left = left_dec;
                if (left_dec == '0)
                begin
                    nxt.accumulator = '0;
                    emit            = 1'b1;
                    res.code_point  = acc_shift;
                end
                else
                    nxt.accumulator = acc_shift;
            end
        end
        else if (is_nul)
        begin
            emit       = 1'b1;
            res.status = ST_END;
        end
        else if (in_byte <= ASCII_MAX)
        begin
            emit           = 1'b1;
            res.code_point = {{(CP_W-7){1'b0}}, in_byte[6:0]};
        end
        else if (in_byte >= LEAD2_MIN && in_byte <= LEAD2_MAX)
        begin
            nxt.accumulator = {{(CP_W-5){1'b0}}, in_byte[4:0]};
            nxt.bytes_left  = LEFT_W'(1);
        end
        else if (in_byte >= LEAD2_MIN && in_byte <= LEAD3_MAX)
        begin
            nxt.accumulator = {{(CP_W-4){1'b0}}, in_byte[3:0]};
            nxt.bytes_left  = LEFT_W'(2);
        end
        else if (in_byte >= LEAD2_MIN && in_byte <= LEAD4_MAX)
        begin
            nxt.accumulator = {{(CP_W-3){1'b0}}, in_byte[2:0]};
            nxt.bytes_left  = LEFT_W'(3);
        end
        else if (in_byte >= LEAD2_MIN && in_byte <= LEAD5_MAX)
        begin
            nxt.accumulator = {{(CP_W-2){1'b0}}, in_byte[1:0]};
            nxt.bytes_left  = LEFT_W'(4);
        end
        else if (in_byte >= LEAD2_MIN && in_byte <= LEAD6_MAX)
        begin
            nxt.accumulator = {{(CP_W-1){1'b0}}, in_byte[0]};
            nxt.bytes_left  = LEFT_W'(5);
        end
        else
        begin
            // 0x80-0xBF, 0xFE, 0xFF: drop bytes until the next NUL
            nxt.accumulator = '0;
            nxt.bytes_left  = '0;
            nxt.halted      = 1'b1;
            emit            = 1'b1;
            res.status      = ST_ILLEGAL;
        end
    end

endmodule

[hw/rtl/u8sd_out_stage.sv]
// ---------------------------------------------------------------------------
// UTF-8 decoder output stage
// Result register with one skid entry; space flag comes from registers only.
// ---------------------------------------------------------------------------
module u8sd_out_stage
    import u8sd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                    skid_valid_reg <= 1'b0;
                else
                    out_valid_reg <= push;
            end
            else if (push)
            begin
                if (!out_valid_reg)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= push_data;
        end
        else if (push)
        begin
            if (!out_valid_reg)
                out_data_reg <= push_data;
            else
                skid_data_reg <= push_data;
        end
    end

endmodule

[hw/rtl/utf8_stream_decoder.sv]
// ---------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes original-form UTF-8 (up to six bytes, 31-bit code points).
// ---------------------------------------------------------------------------
// Usage:
//   Input beats on s_tvalid/s_tready/s_tdata carry one byte each; NUL ends a
//   string. Output beats on m_tvalid/m_tready/m_tdata/m_tuser carry a code
//   point and a status (char, end of string, illegal lead, cut sequence).
//   Lead bytes, non-final continuation bytes and bytes dropped after an illegal lead make no beat.
//   Throughput is one byte per cycle while the skid entry is free. An
//   accepted byte is held in the input register, then decoded into the
//   result register, from which its result, if any, shows on the master side.
//   The decode step is a single pass through masks, a 6-bit shift and the
//   lead byte compare between the input register and the result register.
//   If m_tready drops, one skid entry absorbs the result in flight, then
//   s_tready falls once the input register is also full; nothing is lost.
//   Reset clears the decoder state (no open sequence, not halted) and
//   empties all stages.
// ---------------------------------------------------------------------------
module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [30:0] code_point, [31] zero
    output logic [TUSER_W-1:0] m_tuser    // [1:0] status
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    dec_state_t        state_reg;
    dec_state_t        state_next;
    logic              emit;
    result_t           step_res;
    result_t           out_res;
    logic              space;
    logic              consume;

    assign consume  = in_valid_reg && space;
    assign s_tready = !in_valid_reg || space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (consume)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    u8sd_step u_step (
        .in_byte (in_byte_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .emit    (emit),
        .res     (step_res)
    );

    u8sd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (consume && emit),
        .push_data (step_res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {1'b0, out_res.code_point};
    assign m_tuser = out_res.status;

endmodule

[hw/rtl/u8sd_checker.sv]
// ---------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Port-level properties of the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "utf8_stream_decoder_assert.svh"

module u8sd_checker
    import u8sd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [TUSER_W-1:0] m_tuser
);

    property p_out_hold;
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
    endproperty

    property p_cp_zero_non_char;
        m_tvalid && m_tuser != ST_CHAR |-> m_tdata == '0;
    endproperty

    property p_pad_zero;
        m_tvalid |-> !m_tdata[TDATA_W-1];
    endproperty

    property p_reset_idle;
        $rose(rst_n) |-> !m_tvalid && s_tready;
    endproperty

    property p_ready_after_idle;
        !s_tvalid && !m_tvalid |=> s_tready;
    endproperty

    `U8SD_ASSERT(a_out_hold, p_out_hold, "stalled output beat changed")

    `U8SD_ASSERT(a_cp_zero_non_char, p_cp_zero_non_char, "nonzero code point on a status beat")

    `U8SD_ASSERT(a_pad_zero, p_pad_zero, "pad bit set in output beat")

    // an empty decoder can always take a byte right after reset
    `U8SD_ASSERT_ALWAYS(a_reset_idle, p_reset_idle, "stages not empty after reset")

    // no output beat waiting means the skid entry is free on the next cycle
    `U8SD_ASSERT(a_ready_after_idle, p_ready_after_idle, "input stalled with nothing pending")

endmodule

bind utf8_stream_decoder u8sd_checker u_chk (.*);
